[rtl/response_pattern_likelihood_unit_defines.svh]
// Assertion macros for the response pattern likelihood unit.
// Included by the top level; no other dependencies.
`ifndef RESPONSE_PATTERN_LIKELIHOOD_UNIT_DEFINES_SVH
`define RESPONSE_PATTERN_LIKELIHOOD_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RPL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RPL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/rpl_pkg.sv]
// Shared types and constants of the response pattern likelihood unit.
// No dependencies.
package rpl_pkg;

	localparam int TAG_W = 6;

	localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
	localparam logic [31:0] QNAN_BITS = 32'hFFC0_0000;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RESP = 1'b1;

	typedef struct packed {
		logic             valid;
		logic [TAG_W-1:0] tag;
		logic [31:0]      prod;
	} rpl_elem_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_EMIT,
		ST_CLEAR
	} rpl_state_t;

endpackage

[rtl/response_pattern_likelihood_unit.sv]
// Response pattern likelihood: a load writes the probability table; a response sends the ring
// of node cells once round, one node per cycle, through the shared path, then drains the pipeline.
// A last item then emits nodes in ring order (from node 0, then one node per cycle without
// stall) and afterwards restarts the products at 1.0.
// Reset: products 1.0, nodes_in_use 16, probability table undefined until loaded.
`include "response_pattern_likelihood_unit_defines.svh"

module response_pattern_likelihood_unit #(
	parameter int MAX_ITEMS = 64,
	parameter int MAX_NODES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [5:0]  item_index,
	input  logic        category,
	input  logic [3:0]  node_index,
	input  logic [31:0] prob_value,
	input  logic [31:0] response_value,
	input  logic        response_present,
	input  logic        last_item,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  node,
	output logic [31:0] likelihood,
	output logic        last_node,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  nodes_in_use
);
	import rpl_pkg::*;

	localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int IW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int DEPTH = MAX_ITEMS * (2 ** NW);
	localparam int PIPE  = 4;
	localparam int RING  = MAX_NODES + PIPE;
	localparam int CW    = $clog2(RING + PIPE);
	localparam int LIM   = (MAX_NODES < 16) ? MAX_NODES : 16;

	rpl_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;

	logic [4:0]  nodes_q;
	logic [4:0]  neff;
	logic        in_acc;
	logic [31:0] item_ext, node_ext;
	logic        item_ok, node_ok;
	logic [IW-1:0] item_q;
	logic        apply_q, resp_last_q, fuzzy_q, right_q;
	logic [31:0] x_q, b_q, b_w;

	rpl_elem_t cell_d [MAX_NODES];
	rpl_elem_t cell_q [MAX_NODES];
	rpl_elem_t ring_out, tap_mod;

	rpl_elem_t elem_s1, elem_s2, elem_s3, elem_s4;
	logic        upd_s1, upd_s2, upd_s3;
	logic [31:0] p0_s1, p1_s1;
	logic [31:0] a_w, c_w, sum_w, r_w;
	logic [31:0] a_s2, c_s2, p_s2, s_s3;

	logic [3:0]  emit_idx_q;
	logic        out_free, emit_hit, emit_end;
	logic        out_valid_q, last_node_q;
	logic [3:0]  node_q;
	logic [31:0] lik_q;

	// configuration
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q <= 5'd16;
		end else if (cfg_valid) begin
			nodes_q <= nodes_in_use;
		end
	end

	always_comb begin
		if (nodes_q == 5'd0) begin
			neff = 5'd1;
		end else if (32'(nodes_q) > LIM) begin
			neff = 5'(LIM);
		end else begin
			neff = nodes_q;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign item_ext = 32'(item_index);
	assign node_ext = 32'(node_index);
	assign item_ok  = item_ext < MAX_ITEMS;
	assign node_ok  = node_ext < MAX_NODES;

	// probability table, one bank per category
	rpl_ram #(.W(32), .D(DEPTH)) u_ram0 (
		.clk   (clk),
		.we    (in_acc && cmd == CMD_LOAD && item_ok && node_ok && !category),
		.waddr ({item_ext[IW-1:0], node_ext[NW-1:0]}),
		.wdata (prob_value),
		.raddr ({item_q, ring_out.tag[NW-1:0]}),
		.rdata (p0_s1)
	);

	rpl_ram #(.W(32), .D(DEPTH)) u_ram1 (
		.clk   (clk),
		.we    (in_acc && cmd == CMD_LOAD && item_ok && node_ok && category),
		.waddr ({item_ext[IW-1:0], node_ext[NW-1:0]}),
		.wdata (prob_value),
		.raddr ({item_q, ring_out.tag[NW-1:0]}),
		.rdata (p1_s1)
	);

	// response beat capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apply_q     <= 1'b0;
			resp_last_q <= 1'b0;
			fuzzy_q     <= 1'b0;
			right_q     <= 1'b0;
		end else if (in_acc && cmd == CMD_RESP) begin
			apply_q     <= response_present && item_ok;
			resp_last_q <= last_item;
			fuzzy_q     <= !response_value[31] && (response_value != 32'd0)
				&& (response_value < ONE_BITS);
			right_q     <= !response_value[31] && (response_value >= ONE_BITS)
				&& (response_value <= 32'h7F80_0000);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && cmd == CMD_RESP) begin
			item_q <= item_ext[IW-1:0];
			x_q    <= response_value;
		end
		b_q <= b_w;
	end

	rpl_fadd u_one_minus_x (.a(ONE_BITS), .b({~x_q[31], x_q[30:0]}), .y(b_w));

	// node ring; tags reversed along the chain so nodes leave the tail in ascending order
	assign ring_out = cell_q[MAX_NODES-1];

	always_comb begin
		tap_mod = elem_s4;
		if (state_q == ST_CLEAR) begin
			tap_mod.prod = ONE_BITS;
		end
	end

	for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
		if (k == 0) begin : g_head
			assign cell_d[k] = tap_mod;
		end else begin : g_body
			assign cell_d[k] = cell_q[k-1];
		end
		rpl_cell #(.INDEX(MAX_NODES - 1 - k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (cell_d[k]),
			.q      (cell_q[k])
		);
	end

	// shared multiply-add path
	rpl_fmul u_mul_a (.a(p1_s1), .b(x_q), .y(a_w));
	rpl_fmul u_mul_c (.a(p0_s1), .b(b_q), .y(c_w));
	rpl_fadd u_add   (.a(a_s2), .b(c_s2), .y(sum_w));
	rpl_fmul u_mul_r (.a(elem_s3.prod), .b(s_s3), .y(r_w));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_s1 <= '0;
			elem_s2 <= '0;
			elem_s3 <= '0;
			elem_s4 <= '0;
			upd_s1  <= 1'b0;
			upd_s2  <= 1'b0;
			upd_s3  <= 1'b0;
		end else begin
			elem_s1 <= ring_out;
			upd_s1  <= (state_q == ST_UPDATE) && apply_q && (cnt_q < CW'(RING));
			elem_s2 <= elem_s1;
			upd_s2  <= upd_s1;
			elem_s3 <= elem_s2;
			upd_s3  <= upd_s2;
			elem_s4 <= elem_s3;
			if (upd_s3) begin
				elem_s4.prod <= r_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		a_s2 <= a_w;
		c_s2 <= c_w;
		p_s2 <= right_q ? p1_s1 : p0_s1;
		s_s3 <= fuzzy_q ? sum_w : p_s2;
	end

	// emission
	assign out_free = !out_valid_q || !out_stall;
	assign emit_hit = (state_q == ST_EMIT) && elem_s4.valid && out_free
		&& (elem_s4.tag == TAG_W'(emit_idx_q));
	assign emit_end = emit_hit && ({1'b0, emit_idx_q} == neff - 5'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q != ST_EMIT) begin
				emit_idx_q <= '0;
			end else if (emit_hit) begin
				emit_idx_q <= emit_idx_q + 4'd1;
			end
			if (emit_hit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_hit) begin
			node_q      <= emit_idx_q;
			lik_q       <= elem_s4.prod;
			last_node_q <= emit_end;
		end
	end

	assign out_valid  = out_valid_q;
	assign node       = node_q;
	assign likelihood = lik_q;
	assign last_node  = last_node_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && cmd == CMD_RESP) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				// one full ring pass plus pipeline drain
				if (cnt_q == CW'(RING + PIPE - 1)) begin
					state_d = resp_last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (emit_end) state_d = ST_CLEAR;
			end
			ST_CLEAR: begin
				if (cnt_q == CW'(RING - 1)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`RPL_ASSERT_IMPL(a_last_node, clk, arst_n, out_valid_q && last_node_q, node_q == 4'(neff - 5'd1))
	`RPL_ASSERT_IMPL(a_emit_settled, clk, arst_n, state_q == ST_EMIT, !(upd_s1 || upd_s2 || upd_s3))
	`RPL_ASSERT_NEXT(a_resp_busy, clk, arst_n, in_valid && !in_stall && (cmd == CMD_RESP), in_stall)

endmodule

[rtl/rpl_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rpl_ram #(
	parameter int W = 32,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/rpl_cell.sv]
// One cell of the node ring: holds one node's running product.
// Uses rpl_pkg.
module rpl_cell #(
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rpl_pkg::rpl_elem_t d,
	output rpl_pkg::rpl_elem_t q
);
	import rpl_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q.valid <= 1'b1;
			q.tag   <= TAG_W'(INDEX);
			q.prod  <= ONE_BITS;
		end else begin
			q <= d;
		end
	end

endmodule

[rtl/rpl_fmul.sv]
// Single precision multiply, round to nearest even, subnormals kept.
// Uses rpl_pkg.
module rpl_fmul (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import rpl_pkg::*;

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

	always_comb begin
		logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sy;
		logic [23:0] ma, mb;
		logic [9:0]  ea, eb;
		logic [47:0] p, pn, psh;
		logic [5:0]  lz;
		logic signed [11:0] e;
		logic [6:0]  shamt;
		logic        lost, g, st, up;
		logic [23:0] keep;
		logic [31:0] pk;

		a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		sy     = a[31] ^ b[31];
		ma     = {a[30:23] != 8'd0, a[22:0]};
		mb     = {b[30:23] != 8'd0, b[22:0]};
		ea     = (a[30:23] == 8'd0) ? 10'd1 : {2'b00, a[30:23]};
		eb     = (b[30:23] == 8'd0) ? 10'd1 : {2'b00, b[30:23]};
		p      = ma * mb;
		lz     = lzc48(p);
		pn     = p << lz;
		e      = 12'(ea) + 12'(eb) - 12'sd126 - 12'(lz);
		// tiny result: denormalise with sticky
		if (e < 12'sd1) begin
			shamt = (e < -12'sd48) ? 7'd49 : 7'(12'sd1 - e);
			e     = 12'sd1;
		end else begin
			shamt = 7'd0;
		end
		if (shamt >= 7'd48) begin
			psh  = 48'd0;
			lost = |pn;
		end else begin
			psh  = pn >> shamt;
			lost = |(pn << (7'd48 - shamt));
		end
		keep = psh[47:24];
		g    = psh[23];
		st   = (|psh[22:0]) | lost;
		up   = g & (st | keep[0]);
		pk   = {1'b0, 8'(e - 12'sd1), 23'd0} + {8'd0, keep} + {31'd0, up};

		if (a_nan) begin
			y = a | 32'h0040_0000;
		end else if (b_nan) begin
			y = b | 32'h0040_0000;
		end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
			y = QNAN_BITS;
		end else if (a_inf || b_inf) begin
			y = {sy, 8'hFF, 23'd0};
		end else if (a_zero || b_zero) begin
			y = {sy, 31'd0};
		end else if (e >= 12'sd255 || pk >= 32'h7F80_0000) begin
			y = {sy, 8'hFF, 23'd0};
		end else begin
			y = {sy, pk[30:0]};
		end
	end

endmodule

[rtl/rpl_fadd.sv]
// Single precision add, round to nearest even, subnormals kept.
// Uses rpl_pkg.
module rpl_fadd (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import rpl_pkg::*;

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		n = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (v[i]) n = 5'(26 - i);
		end
		return n;
	endfunction

	always_comb begin
		logic        a_nan, b_nan, a_inf, b_inf;
		logic [31:0] l, s;
		logic [8:0]  el, es, e, d, shl;
		logic [26:0] ml, ms, mss, m;
		logic [27:0] sum;
		logic [4:0]  lz;
		logic        g, st, up;
		logic [23:0] keep;
		logic [31:0] pk;

		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		if (a[30:0] < b[30:0]) begin
			l = b;
			s = a;
		end else begin
			l = a;
			s = b;
		end
		el = (l[30:23] == 8'd0) ? 9'd1 : {1'b0, l[30:23]};
		es = (s[30:23] == 8'd0) ? 9'd1 : {1'b0, s[30:23]};
		ml = {l[30:23] != 8'd0, l[22:0], 3'b000};
		ms = {s[30:23] != 8'd0, s[22:0], 3'b000};
		d  = el - es;
		if (d >= 9'd27) begin
			mss = {26'd0, |ms};
		end else begin
			mss = (ms >> d) | {26'd0, |(ms << (9'd27 - d))};
		end
		if (l[31] == s[31]) begin
			sum = {1'b0, ml} + {1'b0, mss};
		end else begin
			sum = {1'b0, ml} - {1'b0, mss};
		end
		lz = lzc27(sum[26:0]);
		if (sum[27]) begin
			m   = {sum[27:2], sum[1] | sum[0]};
			e   = el + 9'd1;
			shl = 9'd0;
		end else begin
			shl = (9'(lz) < el - 9'd1) ? 9'(lz) : el - 9'd1;
			m   = sum[26:0] << shl;
			e   = el - shl;
		end
		keep = m[26:3];
		g    = m[2];
		st   = |m[1:0];
		up   = g & (st | keep[0]);
		pk   = {1'b0, 8'(e - 9'd1), 23'd0} + {8'd0, keep} + {31'd0, up};

		if (a_nan) begin
			y = a | 32'h0040_0000;
		end else if (b_nan) begin
			y = b | 32'h0040_0000;
		end else if (a_inf && b_inf && (a[31] != b[31])) begin
			y = QNAN_BITS;
		end else if (a_inf) begin
			y = a;
		end else if (b_inf) begin
			y = b;
		end else if (sum == 28'd0) begin
			// exact cancellation or two zeros
			y = {a[31] & b[31], 31'd0};
		end else if (e >= 9'd255 || pk >= 32'h7F80_0000) begin
			y = {l[31], 8'hFF, 23'd0};
		end else begin
			y = {l[31], pk[30:0]};
		end
	end

endmodule

[test/response_pattern_likelihood_unit_tb.sv]
// Self-checking testbench for response_pattern_likelihood_unit: loads the probability table,
// runs a directed table and random persons, and checks every node likelihood bit for bit.
// Depends on rpl_pkg and the unit's RTL only.
module response_pattern_likelihood_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rpl_pkg::*;

	typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic        cmd;
		logic [5:0]  item;
		logic        cat;
		logic [3:0]  nidx;
		logic [31:0] pval;
		logic [31:0] rval;
		logic        present;
		logic        last;
		logic [4:0]  cfg_val;
		logic        known;
		logic [31:0] known_lh;
	} stim_row_t;

	typedef struct {
		logic [3:0]  node;
		logic [31:0] lh;
		logic        last;
	} node_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [5:0]  item_index;
	logic        category;
	logic [3:0]  node_index;
	logic [31:0] prob_value;
	logic [31:0] response_value;
	logic        response_present;
	logic        last_item;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  node;
	logic [31:0] likelihood;
	logic        last_node;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  nodes_in_use;

	response_pattern_likelihood_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cmd              (cmd),
		.item_index       (item_index),
		.category         (category),
		.node_index       (node_index),
		.prob_value       (prob_value),
		.response_value   (response_value),
		.response_present (response_present),
		.last_item        (last_item),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.node             (node),
		.likelihood       (likelihood),
		.last_node        (last_node),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.nodes_in_use     (nodes_in_use)
	);

	// predictor state
	logic [31:0]  prob_tbl [64][2][16];
	logic [31:0]  written_map [64];
	logic [31:0]  node_prod [16];
	logic [4:0]   node_count_reg;
	node_result_t pending_likelihoods [$];
	stim_row_t    directed [$];
	int           errors;
	logic         no_gaps;
	int           stall_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

	// ---- single precision arithmetic, round to nearest even ----
	// operand value = m * 2^(k-149)
	function automatic logic [31:0] fp_round(logic s, logic [63:0] m, int k);
		int n;
		int sh;
		int ke;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		if (m == 64'd0)
			return {s, 31'd0};
		n = 63;
		while (!m[n])
			n--;
		sh = n - 23;
		if (k + sh < 0)
			sh = -k;
		if (sh <= 0) begin
			q = m << (-sh);
		end else if (sh >= 64) begin
			q = 64'd0;
		end else begin
			q = m >> sh;
			rem = m & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			if (rem > half || (rem == half && q[0]))
				q = q + 64'd1;
		end
		ke = k + sh;
		if (q[24]) begin
			q = q >> 1;
			ke++;
		end
		if (q[23]) begin
			if (ke + 1 >= 255)
				return {s, 8'hFF, 23'd0};
			return {s, 8'(ke + 1), q[22:0]};
		end
		return {s, 8'h00, q[22:0]};
	endfunction

	function automatic logic is_nan(logic [31:0] a);
		return a[30:23] == 8'hFF && a[22:0] != 23'd0;
	endfunction

	function automatic logic is_inf(logic [31:0] a);
		return a[30:0] == 31'h7F80_0000;
	endfunction

	function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
		logic s;
		logic [63:0] ma;
		logic [63:0] mb;
		int ka;
		int kb;
		if (is_nan(a))
			return a | 32'h0040_0000;
		if (is_nan(b))
			return b | 32'h0040_0000;
		s = a[31] ^ b[31];
		if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
			return QNAN_BITS;
		if (is_inf(a) || is_inf(b))
			return {s, 8'hFF, 23'd0};
		ma = (a[30:23] == 8'd0) ? {41'd0, a[22:0]} : {40'd0, 1'b1, a[22:0]};
		mb = (b[30:23] == 8'd0) ? {41'd0, b[22:0]} : {40'd0, 1'b1, b[22:0]};
		ka = (a[30:23] == 8'd0) ? 0 : int'(a[30:23]) - 1;
		kb = (b[30:23] == 8'd0) ? 0 : int'(b[30:23]) - 1;
		return fp_round(s, ma * mb, ka + kb - 149);
	endfunction

	function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
		logic [31:0] tmp;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] m;
		logic s;
		int ka;
		int kb;
		int d;
		int k;
		if (is_nan(a))
			return a | 32'h0040_0000;
		if (is_nan(b))
			return b | 32'h0040_0000;
		if (is_inf(a) && is_inf(b) && a[31] != b[31])
			return QNAN_BITS;
		if (is_inf(a))
			return a;
		if (is_inf(b))
			return b;
		if (b[30:0] > a[30:0]) begin
			tmp = a;
			a = b;
			b = tmp;
		end
		ma = (a[30:23] == 8'd0) ? {41'd0, a[22:0]} : {40'd0, 1'b1, a[22:0]};
		mb = (b[30:23] == 8'd0) ? {41'd0, b[22:0]} : {40'd0, 1'b1, b[22:0]};
		ka = (a[30:23] == 8'd0) ? 0 : int'(a[30:23]) - 1;
		kb = (b[30:23] == 8'd0) ? 0 : int'(b[30:23]) - 1;
		d = ka - kb;
		if (d <= 38) begin
			ma = ma << d;
			k = kb;
		end else begin
			// smaller operand only counts as a sticky bit
			ma = ma << 38;
			mb = (mb != 64'd0) ? 64'd1 : 64'd0;
			k = ka - 38;
		end
		s = a[31];
		if (a[31] == b[31]) begin
			m = ma + mb;
		end else begin
			m = ma - mb;
			if (m == 64'd0)
				s = 1'b0;
		end
		return fp_round(s, m, k);
	endfunction

	// ---- likelihood predictor ----
	task automatic apply_response(logic [5:0] it, logic [31:0] x);
		logic fuzzy;
		logic right;
		logic [31:0] s;
		fuzzy = !x[31] && x[30:0] != 31'd0 && x[30:0] < 31'h3F80_0000;
		right = !x[31] && x[30:0] >= 31'h3F80_0000 && !is_nan(x);
		for (int t = 0; t < 16; t++) begin
			if (fuzzy)
				s = fp_add(fp_mul(prob_tbl[it][1][t], x),
					fp_mul(prob_tbl[it][0][t], fp_add(ONE_BITS, {~x[31], x[30:0]})));
			else
				s = right ? prob_tbl[it][1][t] : prob_tbl[it][0][t];
			node_prod[t] = fp_mul(node_prod[t], s);
		end
	endtask

	task automatic predict_item(stim_row_t r);
		int n;
		node_result_t res;
		if (r.cmd == CMD_LOAD) begin
			prob_tbl[r.item][r.cat][r.nidx] = r.pval;
			written_map[r.item][{r.cat, r.nidx}] = 1'b1;
			return;
		end
		if (r.present)
			apply_response(r.item, r.rval);
		if (!r.last)
			return;
		n = (node_count_reg == 5'd0) ? 1 : (node_count_reg > 5'd16) ? 16 : int'(node_count_reg);
		for (int t = 0; t < n; t++) begin
			res.node = 4'(t);
			res.lh = r.known ? r.known_lh : node_prod[t];
			res.last = (t == n - 1);
			pending_likelihoods.push_back(res);
		end
		for (int t = 0; t < 16; t++)
			node_prod[t] = ONE_BITS;
	endtask

	// ---- stimulus ----
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 45)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic stim_row_t mk_item(logic c, logic [5:0] it, logic cat, logic [3:0] ni,
			logic [31:0] pv, logic [31:0] rv, logic pr, logic la, logic kn, logic [31:0] klh);
		stim_row_t r;
		r.kind = ROW_ITEM;
		r.cmd = c;
		r.item = it;
		r.cat = cat;
		r.nidx = ni;
		r.pval = pv;
		r.rval = rv;
		r.present = pr;
		r.last = la;
		r.cfg_val = 5'd0;
		r.known = kn;
		r.known_lh = klh;
		return r;
	endfunction

	function automatic stim_row_t mk_cfg(logic [4:0] v);
		stim_row_t r;
		r = mk_item(CMD_LOAD, 6'd0, 1'b0, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0);
		r.kind = ROW_CFG;
		r.cfg_val = v;
		return r;
	endfunction

	// called at a rising edge; returns at the edge that takes the beat, or after the random gap that follows it
	task automatic send_item(stim_row_t r);
		int g;
		in_valid <= 1'b1;
		cmd <= r.cmd;
		item_index <= r.item;
		category <= r.cat;
		node_index <= r.nidx;
		prob_value <= r.pval;
		response_value <= r.rval;
		response_present <= r.present;
		last_item <= r.last;
		do
			@(posedge clk);
		while (in_stall);
		predict_item(r);
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_likelihoods.size() != 0)
			@(posedge clk);
		// let the products restart before touching the register
		repeat (60) @(posedge clk);
	endtask

	task automatic write_node_count(logic [4:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		nodes_in_use <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		node_count_reg = v;
	endtask

	function automatic logic [31:0] rand_prob();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return {1'b0, 8'($urandom_range(100, 126)), 23'($urandom)};
		if (r < 97)
			return {1'($urandom), 8'($urandom_range(0, 254)), 23'($urandom)};
		return {1'($urandom), 8'hFF, 23'd0};
	endfunction

	function automatic logic [31:0] rand_response();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return ONE_BITS;
			2: return $urandom;
			3: return {1'b1, 31'($urandom)};
			default: return {1'b0, 8'($urandom_range(100, 126)), 23'($urandom)};
		endcase
	endfunction

	function automatic int pick_ready_item();
		int ready [$];
		for (int i = 0; i < 64; i++)
			if (&written_map[i])
				ready.push_back(i);
		return ready[$urandom_range(0, ready.size() - 1)];
	endfunction

	task automatic random_phase(int count);
		int sent;
		int len;
		stim_row_t r;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(0, 19))
				0, 1, 2: begin
					r = mk_item(CMD_LOAD, 6'($urandom), 1'($urandom), 4'($urandom), rand_prob(),
						$urandom, 1'($urandom), 1'($urandom), 1'b0, 32'd0);
					send_item(r);
					sent++;
				end
				3: begin
					// skipped answer, possibly closing a person
					r = mk_item(CMD_RESP, 6'($urandom), 1'($urandom), 4'($urandom), $urandom,
						$urandom, 1'b0, 1'($urandom), 1'b0, 32'd0);
					send_item(r);
					sent++;
				end
				default: begin
					len = $urandom_range(1, 5);
					for (int j = 0; j < len; j++) begin
						r = mk_item(CMD_RESP, 6'(pick_ready_item()), 1'($urandom),
							4'($urandom), $urandom, rand_response(),
							$urandom_range(0, 9) != 0, j == len - 1, 1'b0, 32'd0);
						send_item(r);
						sent++;
					end
				end
			endcase
		end
	endtask

	// ---- result side ----
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!no_gaps && $urandom_range(0, 99) < 30) begin
			out_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50) :
				$urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		node_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_likelihoods.size() == 0) begin
				$display("%0t: unexpected beat node %0d likelihood %h last %b",
					$time, node, likelihood, last_node);
				errors++;
			end else begin
				e = pending_likelihoods.pop_front();
				if (node !== e.node) begin
					$display("%0t: node expected %0d actual %0d", $time, e.node, node);
					errors++;
				end
				if (likelihood !== e.lh) begin
					$display("%0t: likelihood node %0d expected %h actual %h",
						$time, e.node, e.lh, likelihood);
					errors++;
				end
				if (last_node !== e.last) begin
					$display("%0t: last_node node %0d expected %b actual %b",
						$time, e.node, e.last, last_node);
					errors++;
				end
			end
		end
	end

	// ---- main sequence ----
	initial begin
		logic [4:0] phase_cfg [5];
		errors = 0;
		no_gaps = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		item_index = 6'd0;
		category = 1'b0;
		node_index = 4'd0;
		prob_value = 32'd0;
		response_value = 32'd0;
		response_present = 1'b0;
		last_item = 1'b0;
		cfg_valid = 1'b0;
		nodes_in_use = 5'd0;
		node_count_reg = 5'd16;
		for (int i = 0; i < 64; i++)
			written_map[i] = 32'd0;
		for (int t = 0; t < 16; t++)
			node_prod[t] = ONE_BITS;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// table fill: item 3 random, item 9 with p1 = 0.5 and p0 = 0.25 everywhere
		for (int i = 0; i < 10; i++) begin
			if (i != 3 && i != 9)
				continue;
			for (int c = 0; c < 2; c++)
				for (int t = 0; t < 16; t++)
					send_item(mk_item(CMD_LOAD, 6'(i), 1'(c), 4'(t),
						(i == 9) ? (c ? 32'h3F00_0000 : 32'h3E80_0000) : rand_prob(),
						$urandom, 1'b0, 1'b0, 1'b0, 32'd0));
		end

		directed.push_back(mk_item(CMD_RESP, 6'd0, 1'b0, 4'd0, 32'd0, 32'd0, 1'b0, 1'b1,
			1'b1, ONE_BITS));
		directed.push_back(mk_item(CMD_RESP, 6'd9, 1'b1, 4'd15, 32'hFFFF_FFFF, ONE_BITS,
			1'b1, 1'b1, 1'b1, 32'h3F00_0000));
		directed.push_back(mk_item(CMD_RESP, 6'd9, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1, 1'b1,
			1'b1, 32'h3E80_0000));
		directed.push_back(mk_item(CMD_RESP, 6'd9, 1'b0, 4'd0, 32'd0, 32'h3F00_0000, 1'b1,
			1'b1, 1'b1, 32'h3EC0_0000));
		directed.push_back(mk_item(CMD_RESP, 6'd9, 1'b0, 4'd0, 32'd0, 32'h4000_0000, 1'b1,
			1'b1, 1'b1, 32'h3F00_0000));
		directed.push_back(mk_item(CMD_RESP, 6'd9, 1'b0, 4'd0, 32'd0, 32'hBF80_0000, 1'b1,
			1'b1, 1'b1, 32'h3E80_0000));
		directed.push_back(mk_item(CMD_RESP, 6'd9, 1'b0, 4'd0, 32'd0, 32'h7FC0_0000, 1'b1,
			1'b1, 1'b1, 32'h3E80_0000));
		directed.push_back(mk_item(CMD_RESP, 6'd9, 1'b0, 4'd0, 32'd0, 32'h7F80_0000, 1'b1,
			1'b1, 1'b1, 32'h3F00_0000));
		directed.push_back(mk_cfg(5'd1));
		directed.push_back(mk_item(CMD_RESP, 6'd9, 1'b0, 4'd0, 32'd0, ONE_BITS, 1'b1, 1'b1,
			1'b1, 32'h3F00_0000));
		directed.push_back(mk_cfg(5'd0));
		directed.push_back(mk_item(CMD_RESP, 6'd9, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1, 1'b1,
			1'b1, 32'h3E80_0000));
		directed.push_back(mk_cfg(5'd31));
		// load carrying last_item emits nothing
		directed.push_back(mk_item(CMD_LOAD, 6'd9, 1'b1, 4'd0, 32'h3F00_0000, 32'd0, 1'b1,
			1'b1, 1'b0, 32'd0));
		directed.push_back(mk_item(CMD_RESP, 6'd3, 1'b0, 4'd0, 32'd0, 32'h3E99_999A, 1'b1,
			1'b0, 1'b0, 32'd0));
		directed.push_back(mk_item(CMD_RESP, 6'd3, 1'b0, 4'd0, 32'd0, 32'h3F33_3333, 1'b1,
			1'b0, 1'b0, 32'd0));
		directed.push_back(mk_item(CMD_RESP, 6'd63, 1'b1, 4'd15, 32'd0, 32'hFFFF_FFFF, 1'b0,
			1'b0, 1'b0, 32'd0));
		directed.push_back(mk_item(CMD_RESP, 6'd9, 1'b0, 4'd0, 32'd0, 32'h0001_1000, 1'b1,
			1'b1, 1'b0, 32'd0));
		directed.push_back(mk_item(CMD_LOAD, 6'd63, 1'b1, 4'd15, 32'h7F7F_FFFF, 32'd0, 1'b0,
			1'b0, 1'b0, 32'd0));
		directed.push_back(mk_cfg(5'd16));

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG)
				write_node_count(directed[i].cfg_val);
			else
				send_item(directed[i]);
		end

		phase_cfg[0] = 5'd16;
		phase_cfg[1] = 5'd1;
		phase_cfg[2] = 5'($urandom_range(2, 15));
		phase_cfg[3] = 5'd31;
		phase_cfg[4] = 5'd0;
		for (int p = 0; p < 5; p++) begin
			write_node_count(phase_cfg[p]);
			no_gaps = (p == 2);
			random_phase(18);
		end
		no_gaps = 1'b0;
		wait_idle();

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
